// File: rtl/kvi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package kvi_pkg;
    typedef enum logic [0:0] {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_opcode;

    localparam logic [0:0] REG_ENTRY_COUNT = 1'b0;
    localparam logic [0:0] REG_INTERP_EN   = 1'b1;

    localparam int DW = 32;
    localparam int FRAC_BITS = 30;

    // table depth and entry index width
    localparam int MAX_ENTRIES = 64;
    localparam int IDX_W = 6;

    // one table entry: key and xyz value
    typedef struct packed {
        logic signed [DW-1:0] key;
        logic signed [DW-1:0] vx;
        logic signed [DW-1:0] vy;
        logic signed [DW-1:0] vz;
    } t_entry;

    function automatic logic signed [DW-1:0] sat32(input logic signed [63:0] v);
        logic signed [DW-1:0] r;
        if (v > 64'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DW-1:0];
        end
        return r;
    endfunction
endpackage
`default_nettype wire

// File: rtl/kvi_table.sv
`timescale 1ns / 1ps
`default_nettype none
module kvi_table #(
    parameter int DEPTH = 64,
    parameter int AW = 6
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  kvi_pkg::t_entry      i_wdata,
    input  wire logic [AW-1:0]   i_raddr,
    output kvi_pkg::t_entry      o_rdata
);
    import kvi_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// File: rtl/kvi_div.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring signed divider, one quotient bit a cycle, truncates toward zero
module kvi_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_num,
    input  wire logic signed [32:0] i_den,
    output logic                    o_done,
    output logic signed [63:0]      o_quo
);
    logic [63:0] r_q, n_q;
    logic [64:0] r_rem, n_rem;
    logic [32:0] r_den;
    logic        r_neg;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [64:0] w_shift;
    logic [64:0] w_trial;

    assign w_shift = {r_rem[63:0], r_q[63]};
    assign w_trial = w_shift - {32'd0, r_den};

    always_comb begin
        n_q   = {r_q[62:0], 1'b0};
        n_rem = w_shift;
        if (!w_trial[64]) begin
            n_rem = w_trial;
            n_q[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num[63] ? 64'(-i_num) : i_num;
            r_den <= i_den[32] ? 33'(-i_den) : i_den;
            r_rem <= '0;
            r_neg <= i_num[63] ^ i_den[32];
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule
`default_nettype wire

// File: rtl/kvi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module kvi_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic              i_opcode,
    input  wire logic signed [31:0] i_fraction,
    input  wire logic [6:0]        i_entry_count,
    input  wire logic              i_interp_en,
    output logic [kvi_pkg::IDX_W-1:0] o_raddr,
    input  kvi_pkg::t_entry        i_rdata,
    output logic                   o_div_start,
    output logic signed [63:0]     o_div_num,
    output logic signed [32:0]     o_div_den,
    input  wire logic              i_div_done,
    input  wire logic signed [63:0] i_div_quo,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic signed [31:0]     o_out_x,
    output logic signed [31:0]     o_out_y,
    output logic signed [31:0]     o_out_z,
    output logic [5:0]             o_segment_used
);
    import kvi_pkg::*;

    localparam int AW = IDX_W;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_RLAST = 10'b00_0000_0010,
        S_RFST  = 10'b00_0000_0100,
        S_UP    = 10'b00_0000_1000,
        S_DOWN  = 10'b00_0001_0000,
        S_RSEG  = 10'b00_0010_0000,
        S_RNXT  = 10'b00_0100_0000,
        S_DIV   = 10'b00_1000_0000,
        S_MUL   = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    logic [CW-1:0] r_n;
    logic [CW-1:0] w_cnt;
    logic [AW-1:0] r_loc;
    logic [AW-1:0] r_last;
    logic [AW-1:0] r_addr;
    logic signed [31:0] r_f;
    t_entry r_e0, r_e1, r_last_e;
    logic signed [31:0] r_ratio;
    logic [1:0] r_comp;
    logic signed [63:0] r_acc [3];
    logic signed [31:0] r_ox, r_oy, r_oz;
    logic [5:0] r_seg;
    logic r_ovalid;
    logic r_wait;
    logic r_div_start;

    assign w_cnt = (i_entry_count > 7'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(i_entry_count);
    assign o_raddr = r_addr;
    assign o_div_start = r_div_start;

    // one multiplier shared across components
    logic signed [32:0] w_d;
    logic signed [65:0] w_prod;
    logic signed [31:0] w_v0;
    logic signed [31:0] w_v1;
    always_comb begin
        unique case (r_comp)
            2'd0: begin w_v0 = r_e0.vx; w_v1 = r_e1.vx; end
            2'd1: begin w_v0 = r_e0.vy; w_v1 = r_e1.vy; end
            default: begin w_v0 = r_e0.vz; w_v1 = r_e1.vz; end
        endcase
        w_d = 33'(w_v1) - 33'(w_v0);
        w_prod = 66'(r_ratio) * 66'(w_d);
    end

    logic signed [65:0] w_sum;
    assign w_sum = ($signed(66'(w_v0)) <<< FRAC_BITS) + w_prod;

    logic signed [31:0] w_kd_sel;
    logic signed [32:0] w_kd;
    logic signed [32:0] w_fd;
    assign w_kd = 33'(r_e1.key) - 33'(r_e0.key);
    assign w_fd = 33'(r_f) - 33'(r_e0.key);
    assign w_kd_sel = r_e0.key;

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_out_x = r_ox;
    assign o_out_y = r_oy;
    assign o_out_z = r_oz;
    assign o_segment_used = r_seg;

    logic signed [63:0] w_ratio_sat;
    always_comb begin
        w_ratio_sat = i_div_quo;
        if (i_div_quo > 64'sd1073741824) w_ratio_sat = 64'sd1073741824;
        if (i_div_quo < -64'sd1073741824) w_ratio_sat = -64'sd1073741824;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ovalid    <= 1'b0;
            r_last      <= '0;
            r_wait      <= 1'b0;
            r_addr      <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            r_wait <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready && i_opcode == OP_EVAL) begin
                        r_f <= i_fraction;
                        r_n <= w_cnt;
                        if (w_cnt == '0) begin
                            r_ox <= '0; r_oy <= '0; r_oz <= '0; r_seg <= '0;
                            r_ovalid <= 1'b1;
                        end else begin
                            r_addr <= AW'(w_cnt - CW'(1));
                            r_wait <= 1'b1;
                            r_state <= S_RLAST;
                        end
                    end
                end
                S_RLAST: begin
                    if (!r_wait) begin
                        r_last_e <= i_rdata;
                        r_addr <= '0;
                        r_wait <= 1'b1;
                        r_state <= S_RFST;
                    end
                end
                S_RFST: begin
                    if (!r_wait) begin
                        r_e0 <= i_rdata;
                        if (r_n == CW'(1)) begin
                            r_ox <= i_rdata.vx; r_oy <= i_rdata.vy; r_oz <= i_rdata.vz;
                            r_seg <= '0; r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else if (r_f >= r_last_e.key) begin
                            r_ox <= r_last_e.vx; r_oy <= r_last_e.vy; r_oz <= r_last_e.vz;
                            r_seg <= 6'(r_n - CW'(1)); r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else if (r_f <= i_rdata.key) begin
                            r_ox <= i_rdata.vx; r_oy <= i_rdata.vy; r_oz <= i_rdata.vz;
                            r_seg <= '0; r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else begin
                            r_loc <= (CW'(r_last) > r_n - CW'(2)) ? AW'(r_n - CW'(2)) : r_last;
                            r_addr <= ((CW'(r_last) > r_n - CW'(2)) ? AW'(r_n - CW'(2)) : r_last)
                                      + AW'(1);
                            r_wait <= 1'b1;
                            r_state <= S_UP;
                        end
                    end
                end
                // walk up: read key[loc+1]
                S_UP: begin
                    if (!r_wait) begin
                        if (CW'(r_loc) + CW'(1) < r_n && r_f > i_rdata.key) begin
                            r_loc <= r_loc + AW'(1);
                            r_addr <= r_loc + AW'(2);
                            r_wait <= 1'b1;
                            if (CW'(r_loc) + CW'(2) >= r_n) begin
                                r_addr <= r_loc + AW'(1);
                                r_state <= S_DOWN;
                            end
                        end else begin
                            r_addr <= r_loc;
                            r_wait <= 1'b1;
                            r_state <= S_DOWN;
                        end
                    end
                end
                // walk down: read key[loc]
                S_DOWN: begin
                    if (!r_wait) begin
                        if (r_loc != '0 && r_f < i_rdata.key) begin
                            r_loc <= r_loc - AW'(1);
                            r_addr <= r_loc - AW'(1);
                            r_wait <= 1'b1;
                        end else begin
                            if (CW'(r_loc) > r_n - CW'(2)) begin
                                r_loc <= AW'(r_n - CW'(2));
                                r_addr <= AW'(r_n - CW'(2));
                            end else begin
                                r_addr <= r_loc;
                            end
                            r_wait <= 1'b1;
                            r_state <= S_RSEG;
                        end
                    end
                end
                S_RSEG: begin
                    if (!r_wait) begin
                        r_e0 <= i_rdata;
                        r_last <= r_loc;
                        r_seg <= 6'(r_loc);
                        r_addr <= r_loc + AW'(1);
                        r_wait <= 1'b1;
                        r_state <= S_RNXT;
                    end
                end
                S_RNXT: begin
                    if (!r_wait) begin
                        r_e1 <= i_rdata;
                        if (!i_interp_en || i_rdata.key == w_kd_sel) begin
                            r_ox <= r_e0.vx; r_oy <= r_e0.vy; r_oz <= r_e0.vz;
                            r_ovalid <= 1'b1; r_state <= S_IDLE;
                        end else begin
                            r_div_start <= 1'b1;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    if (i_div_done) begin
                        r_ratio <= w_ratio_sat[31:0];
                        r_comp <= 2'd0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_acc[r_comp] <= 64'(w_sum >>> FRAC_BITS);
                    r_comp <= r_comp + 2'd1;
                    if (r_comp == 2'd2) r_state <= S_OUT;
                end
                S_OUT: begin
                    r_ox <= sat32(r_acc[0]);
                    r_oy <= sat32(r_acc[1]);
                    r_oz <= sat32(r_acc[2]);
                    r_ovalid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_div_num = $signed(64'(w_fd)) <<< FRAC_BITS;
    assign o_div_den = w_kd;
endmodule
`default_nettype wire

// File: rtl/keyframe_vector_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// keyframe vector interpolator, xyz values in signed q16.16
// input channel: i_valid/o_ready; opcode load writes one key/value entry
//   (no result), opcode evaluate returns one vector on the output channel
// output channel: o_valid/i_ready, held stable until the transaction completes
// config channel: i_cfg_valid/o_cfg_ready, index 0 entry_count, 1 interpolate_enable
// sequence: a load is taken while idle and another can follow at once;
//   evaluate with an empty table answers in the cycle after it is taken, the
//   one entry and clamped cases after reading the last and first entries, a
//   searched segment holding its start value at the end of the search
// interpolating adds the bit-serial ratio divider (start, 64 quotient bits,
//   hand-back) and the shared multiplier pass over x, y and z and the output
//   register
// one evaluate is in flight at a time; the table memory read port (each
//   registered read is awaited before the next) and the divider set the rate,
//   and the next input is taken in the cycle after the result drains
// reset clears control state, the remembered segment and the registers
//   (entry_count 0, interpolate_enable 1); table contents are undefined
//   until written
// if the receiver stalls the finished result is held and no new input
//   transaction is taken until it drains
module keyframe_vector_interpolator (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [0:0]         i_opcode,
    input  wire logic [5:0]         i_entry_index,
    input  wire logic signed [31:0] i_key_in,
    input  wire logic signed [31:0] i_load_x,
    input  wire logic signed [31:0] i_load_y,
    input  wire logic signed [31:0] i_load_z,
    input  wire logic signed [31:0] i_fraction,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [31:0]      o_out_x,
    output logic signed [31:0]      o_out_y,
    output logic signed [31:0]      o_out_z,
    output logic [5:0]              o_segment_used,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [0:0]         i_cfg_index,
    input  wire logic [31:0]        i_cfg_data
);
    import kvi_pkg::*;

    localparam int AW = IDX_W;

    logic [6:0] r_entry_count;
    logic       r_interp_en;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_interp_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENTRY_COUNT: r_entry_count <= i_cfg_data[6:0];
                REG_INTERP_EN:   r_interp_en   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // table write on a load transaction
    logic   w_we;
    t_entry w_wdata;
    t_entry w_rdata;
    logic [AW-1:0] w_raddr;
    assign w_we = i_valid && o_ready && (i_opcode == OP_LOAD)
                  && (32'(i_entry_index) < 32'(MAX_ENTRIES));
    assign w_wdata = '{key: i_key_in, vx: i_load_x, vy: i_load_y, vz: i_load_z};

    kvi_table #(.DEPTH(MAX_ENTRIES), .AW(AW)) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic               w_div_start;
    logic signed [63:0] w_div_num;
    logic signed [32:0] w_div_den;
    logic               w_div_done;
    logic signed [63:0] w_div_quo;

    kvi_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    kvi_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_opcode       (i_opcode),
        .i_fraction     (i_fraction),
        .i_entry_count  (r_entry_count),
        .i_interp_en    (r_interp_en),
        .o_raddr        (w_raddr),
        .i_rdata        (w_rdata),
        .o_div_start    (w_div_start),
        .o_div_num      (w_div_num),
        .o_div_den      (w_div_den),
        .i_div_done     (w_div_done),
        .i_div_quo      (w_div_quo),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_out_z        (o_out_z),
        .o_segment_used (o_segment_used)
    );
endmodule
`default_nettype wire

// File: rtl/kvi_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module kvi_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_ready,
    input wire logic [0:0] i_opcode,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [31:0] o_out_x,
    input wire logic [5:0] o_segment_used
);
    import kvi_pkg::*;

    // result held while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_x) && $stable(o_segment_used))
        else $error("result changed while stalled");

    // no new input transaction while a result waits
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result pending");

    // a load never produces a result next cycle
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_opcode == OP_LOAD && !o_valid |=> !o_valid)
        else $error("load produced a result");

    // nothing valid out of reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("valid after reset");
endmodule

bind keyframe_vector_interpolator kvi_checker u_kvi_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .i_opcode       (i_opcode),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_out_x        (o_out_x),
    .o_segment_used (o_segment_used)
);
`default_nettype wire
